// ===== rtl/tle_pkg.sv =====
package tle_pkg;

  // Default line length and keystroke codes
  localparam int LINE_LENGTH_DEF = 40;

  localparam logic [7:0] KEY_EOF    = 8'd4;
  localparam logic [7:0] KEY_KILL   = 8'd21;
  localparam logic [7:0] KEY_WERASE = 8'd23;
  localparam logic [7:0] KEY_DEL    = 8'd127;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [6:0] SPACE_CHAR = 7'd32;

  localparam int CHAR_W = 7;

  typedef enum logic [1:0] {
    ACT_ECHO    = 2'd0,
    ACT_ERASE   = 2'd1,
    ACT_BELL    = 2'd2,
    ACT_NEWLINE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_EOF,
    KIND_DEL,
    KIND_KILL,
    KIND_WERASE,
    KIND_PRINT,
    KIND_OTHER
  } key_kind_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_INC,
    CUR_DEC,
    CUR_CLEAR
  } cursor_op_t;

  // Read address relative to the cursor
  typedef enum logic [1:0] {
    RD_BACK1,
    RD_BACK2,
    RD_BACK3
  } rd_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_KILL,
    ST_WFETCH,
    ST_WLOAD,
    ST_WSTEP,
    ST_NEWLINE
  } state_t;

  typedef struct packed {
    logic       key_load;
    logic       out_load;
    action_t    out_action;
    logic       out_echo;
    logic       out_eoi;
    logic       out_last;
    cursor_op_t cursor_op;
    logic       store_we;
    rd_sel_t    rd_sel;
    logic       phase_init;
    logic       cur_load;
    logic       walk_advance;
  } tle_cmd_t;

  typedef struct packed {
    key_kind_t kind;
    logic      cursor_zero;
    logic      cursor_one;
    logic      cursor_at_end;
    logic      out_free;
    logic      word_last;
  } tle_sts_t;

  // Classify a keystroke byte
  function automatic key_kind_t classify(input logic [7:0] key);
    key_kind_t kind;
    if (key == KEY_EOF) begin
      kind = KIND_EOF;
    end else if (key == KEY_DEL) begin
      kind = KIND_DEL;
    end else if (key == KEY_KILL) begin
      kind = KIND_KILL;
    end else if (key == KEY_WERASE) begin
      kind = KIND_WERASE;
    end else if (key >= PRINT_LOW && key <= PRINT_HIGH) begin
      kind = KIND_PRINT;
    end else begin
      kind = KIND_OTHER;
    end
    return kind;
  endfunction

endpackage

// ===== rtl/tle_ram.sv =====
module tle_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tle_datapath.sv =====
module tle_datapath #(
  parameter int LINE_LENGTH = tle_pkg::LINE_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  tle_pkg::tle_cmd_t cmd,
  output tle_pkg::tle_sts_t sts,
  input  logic [7:0]       key_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_action,
  output logic [6:0]       out_char,
  output logic             out_eoi,
  output logic             out_last
);

  import tle_pkg::*;

  localparam int AW = $clog2(LINE_LENGTH);

  logic [7:0]        key;
  logic [AW-1:0]     cursor;
  logic [AW-1:0]     cursor_next;
  logic              phase_space;
  logic [CHAR_W-1:0] cur_ch;
  logic [CHAR_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [1:0]        rd_back;
  logic              phase_after;

  // Hold the accepted keystroke
  always_ff @(posedge clk) begin
    if (cmd.key_load) begin
      key <= key_in;
    end
  end

  // Step the cursor forward or back, or clear it
  always_comb begin
    case (cmd.cursor_op)
      CUR_INC:   cursor_next = cursor + AW'(1);
      CUR_DEC:   cursor_next = cursor - AW'(1);
      CUR_CLEAR: cursor_next = '0;
      default:   cursor_next = cursor;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      cursor <= cursor_next;
    end
  end

  // Pick the read address behind the cursor; clamp below zero
  always_comb begin
    case (cmd.rd_sel)
      RD_BACK2: rd_back = 2'd2;
      RD_BACK3: rd_back = 2'd3;
      default:  rd_back = 2'd1;
    endcase
    if (cursor < AW'(rd_back)) begin
      rd_addr = '0;
    end else begin
      rd_addr = cursor - AW'(rd_back);
    end
  end

  tle_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(LINE_LENGTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store_we),
    .waddr(cursor),
    .wdata(key[CHAR_W-1:0]),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Word-erase walk: current character and space phase
  assign phase_after = phase_space && (cur_ch == SPACE_CHAR);

  always_ff @(posedge clk) begin
    if (cmd.phase_init) begin
      phase_space <= 1'b1;
    end else if (cmd.walk_advance) begin
      phase_space <= phase_after;
    end
    if (cmd.cur_load || cmd.walk_advance) begin
      cur_ch <= rd_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_action <= cmd.out_action;
      out_char   <= cmd.out_echo ? key[CHAR_W-1:0] : '0;
      out_eoi    <= cmd.out_eoi;
      out_last   <= cmd.out_last;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.kind          = classify(key);
    sts.cursor_zero   = (cursor == '0);
    sts.cursor_one    = (cursor == AW'(1));
    sts.cursor_at_end = (cursor == AW'(LINE_LENGTH - 1));
    sts.out_free      = !out_valid || out_ready;
    sts.word_last     = (cursor == AW'(1)) || (!phase_after && (rd_data == SPACE_CHAR));
  end

endmodule

// ===== rtl/tle_ctrl.sv =====
module tle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tle_pkg::tle_sts_t sts,
  output tle_pkg::tle_cmd_t cmd
);

  import tle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.kind)
          KIND_KILL: begin
            state_next = sts.cursor_zero ? ST_IDLE : ST_KILL;
          end
          KIND_WERASE: begin
            state_next = sts.cursor_zero ? ST_IDLE : ST_WFETCH;
          end
          KIND_PRINT: begin
            if (sts.out_free) begin
              state_next = sts.cursor_at_end ? ST_NEWLINE : ST_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_KILL: begin
        if (sts.out_free && sts.cursor_one) begin
          state_next = ST_IDLE;
        end
      end
      ST_WFETCH: state_next = ST_WLOAD;
      ST_WLOAD:  state_next = ST_WSTEP;
      ST_WSTEP: begin
        if (sts.out_free && sts.word_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_NEWLINE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.out_action   = ACT_BELL;
    cmd.cursor_op    = CUR_HOLD;
    cmd.rd_sel       = RD_BACK1;
    unique case (state)
      ST_IDLE: begin
        // Refuse transfers while reset is held
        in_ready     = !rst;
        cmd.key_load = in_valid && !rst;
      end
      ST_DECODE: begin
        unique case (sts.kind)
          KIND_EOF: begin
            cmd.out_load   = sts.out_free;
            cmd.out_last   = 1'b1;
            cmd.out_action = sts.cursor_zero ? ACT_NEWLINE : ACT_BELL;
            cmd.out_eoi    = sts.cursor_zero;
          end
          KIND_DEL: begin
            cmd.out_load   = sts.out_free;
            cmd.out_last   = 1'b1;
            cmd.out_action = sts.cursor_zero ? ACT_BELL : ACT_ERASE;
            if (sts.out_free && !sts.cursor_zero) begin
              cmd.cursor_op = CUR_DEC;
            end
          end
          KIND_KILL: begin
            cmd.out_load = 1'b0;
          end
          KIND_WERASE: begin
            cmd.phase_init = 1'b1;
          end
          KIND_PRINT: begin
            cmd.out_load   = sts.out_free;
            cmd.out_action = ACT_ECHO;
            cmd.out_echo   = 1'b1;
            cmd.out_last   = !sts.cursor_at_end;
            cmd.store_we   = sts.out_free;
            if (sts.out_free) begin
              cmd.cursor_op = sts.cursor_at_end ? CUR_CLEAR : CUR_INC;
            end
          end
          default: begin
            cmd.out_load = sts.out_free;
            cmd.out_last = 1'b1;
          end
        endcase
      end
      ST_KILL: begin
        cmd.out_load   = sts.out_free;
        cmd.out_action = ACT_ERASE;
        cmd.out_last   = sts.cursor_one;
        if (sts.out_free) begin
          cmd.cursor_op = CUR_DEC;
        end
      end
      ST_WFETCH: begin
        cmd.rd_sel = RD_BACK1;
      end
      ST_WLOAD: begin
        cmd.cur_load = 1'b1;
        cmd.rd_sel   = RD_BACK2;
      end
      ST_WSTEP: begin
        cmd.out_load     = sts.out_free;
        cmd.out_action   = ACT_ERASE;
        cmd.out_last     = sts.word_last;
        cmd.walk_advance = sts.out_free;
        cmd.rd_sel       = sts.out_free ? RD_BACK3 : RD_BACK2;
        if (sts.out_free) begin
          cmd.cursor_op = CUR_DEC;
        end
      end
      ST_NEWLINE: begin
        cmd.out_load   = sts.out_free;
        cmd.out_action = ACT_NEWLINE;
        cmd.out_last   = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/terminal_line_editor.sv =====
// The first result of a keystroke is registered from the decode state, or from the
// kill or word-erase walk for Ctrl-U and Ctrl-W, which give no result on an empty line.
// A new keystroke is taken only once the last result of the previous one is loaded;
// the line store read port paces the word walk. Back-pressure stalls the controller.
// Reset (rst, synchronous): empty line, cursor at 0, no result pending; store unset.
module terminal_line_editor #(
  parameter int LINE_LENGTH = tle_pkg::LINE_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] key
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] char_out, [7] zero
  output logic [2:0] m_tuser,   // [1:0] action, [2] end_of_input
  output logic       m_tlast
);

  import tle_pkg::*;

  tle_cmd_t   cmd;
  tle_sts_t   sts;
  logic [1:0] action;
  logic [6:0] char_out;
  logic       eoi;

  tle_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tle_datapath #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .key_in    (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_action(action),
    .out_char  (char_out),
    .out_eoi   (eoi),
    .out_last  (m_tlast)
  );

  // Pack the result transfer
  assign m_tdata = {1'b0, char_out};
  assign m_tuser = {eoi, action};

endmodule

// ===== tb/terminal_line_editor_tb.sv =====
`timescale 1ns / 1ps

module terminal_line_editor_tb;
  import tle_pkg::*;

  localparam int LINE_LEN    = LINE_LENGTH_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int RX_HOLD     = 250;
  localparam int RAND_KEYS   = 80;

  typedef struct {
    action_t    act;
    logic [6:0] ch;
    logic       eoi;
    logic       last;
  } disp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] key
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [6:0] char_out, [7] zero
  logic [2:0] m_tuser;          // [1:0] action, [2] end_of_input
  logic       m_tlast;

  // Predicted line state and pending display actions
  logic [6:0] line_mem [0:LINE_LEN-1];
  int         line_cur = 0;
  disp_t      screen_q [$];

  int  mismatch_cnt = 0;
  int  idle_cnt = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stalls_on = 1'b1;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  rx_left = 0;

  terminal_line_editor #(.LINE_LENGTH(LINE_LEN)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly short, a few long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_disp(input action_t act, input logic [6:0] ch, input logic eoi);
    disp_t d;
    d.act  = act;
    d.ch   = ch;
    d.eoi  = eoi;
    d.last = 1'b0;
    screen_q.push_back(d);
  endfunction

  function automatic void erase_cell();
    line_cur--;
    push_disp(ACT_ERASE, 7'd0, 1'b0);
  endfunction

  // Apply one keystroke to the predicted line and queue its display actions
  function automatic void edit_line(input logic [7:0] key);
    int    n;
    disp_t d;
    n = 0;
    if (line_cur >= LINE_LEN) line_cur = 0;
    if (key == KEY_EOF && line_cur == 0) begin
      push_disp(ACT_NEWLINE, 7'd0, 1'b1);
      n = 1;
    end else if (key == KEY_DEL) begin
      if (line_cur > 0) erase_cell();
      else push_disp(ACT_BELL, 7'd0, 1'b0);
      n = 1;
    end else if (key == KEY_KILL) begin
      while (line_cur > 0) begin
        erase_cell();
        n++;
      end
    end else if (key == KEY_WERASE) begin
      while (line_cur > 0 && line_mem[line_cur-1] == SPACE_CHAR) begin
        erase_cell();
        n++;
      end
      while (line_cur > 0 && line_mem[line_cur-1] != SPACE_CHAR) begin
        erase_cell();
        n++;
      end
    end else if (key >= PRINT_LOW && key <= PRINT_HIGH) begin
      line_mem[line_cur] = key[6:0];
      line_cur++;
      push_disp(ACT_ECHO, key[6:0], 1'b0);
      n = 1;
      if (line_cur >= LINE_LEN) begin
        push_disp(ACT_NEWLINE, 7'd0, 1'b0);
        n = 2;
        line_cur = 0;
      end
    end else begin
      push_disp(ACT_BELL, 7'd0, 1'b0);
      n = 1;
    end
    if (n > 0) begin
      d = screen_q.pop_back();
      d.last = 1'b1;
      screen_q.push_back(d);
    end
  endfunction

  // Offer one keystroke, predict on transfer, then possibly idle for a random gap
  task automatic send_key(input logic [7:0] key);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    edit_line(key);
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted action has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_printable();
    return 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
  endfunction

  function automatic logic [7:0] word_char();
    return 8'($urandom_range(PRINT_LOW + 1, PRINT_HIGH));
  endfunction

  // Weighted keystroke mix: mostly typing, with edits and noise
  function automatic logic [7:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return word_char();
    if (r < 62) return 8'(SPACE_CHAR);
    if (r < 70) return KEY_DEL;
    if (r < 74) return KEY_KILL;
    if (r < 82) return KEY_WERASE;
    if (r < 86) return KEY_EOF;
    if (r < 93) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic test_directed();
    logic [7:0] seq [$];
    seq = '{8'd255, 8'd128, 8'd0, 8'd31, KEY_DEL, KEY_KILL, KEY_WERASE, KEY_EOF, KEY_EOF,
            8'd119, 8'd32, 8'd32, KEY_EOF, KEY_WERASE, 8'd126, 8'd32, 8'd33, KEY_DEL,
            KEY_KILL, 8'd32, 8'd32, KEY_WERASE, 8'd65, 8'd66, KEY_WERASE};
    foreach (seq[i]) send_key(seq[i]);
    wait_drained();
  endtask

  // Fill the line to wrap, then kill and word-erase the longest lines
  task automatic test_long_lines();
    repeat (LINE_LEN) send_key(any_printable());
    repeat (LINE_LEN - 1) send_key(any_printable());
    send_key(KEY_KILL);
    repeat (LINE_LEN - 1) send_key(word_char());
    send_key(KEY_WERASE);
    repeat (LINE_LEN - 2) send_key(word_char());
    send_key(8'(SPACE_CHAR));
    send_key(KEY_WERASE);
    send_key(KEY_KILL);
    wait_drained();
  endtask

  // Random keystrokes; one quiet stretch, one full pause midway
  task automatic test_random();
    for (int i = 0; i < RAND_KEYS; i++) begin
      tx_gaps_on   = !(i >= 20 && i < 40);
      rx_stalls_on = !(i >= 20 && i < 40);
      if (i == 50) wait_drained();
      send_key(pick_key());
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    wait_drained();
  endtask

  // Hold the receiver off while keys keep coming back to back
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_req++;
    for (int i = 0; i < 60; i++) begin
      if (i % 20 == 19) send_key(KEY_KILL);
      else send_key(any_printable());
    end
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  // Receiver: random stalls, quiet stretches, and a long hold on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = RX_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!rx_stalls_on) begin
      m_tready <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if (!m_tready || $urandom_range(99) < 50) begin
      m_tready <= 1'b1;
      rx_left = $urandom_range(1, 12);
    end else begin
      m_tready <= 1'b0;
      rx_left = idle_len();
    end
  end

  // Compare each output transfer with the oldest predicted action
  always @(posedge clk) begin
    disp_t d;
    if (!rst && m_tvalid && m_tready) begin
      if (screen_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected transfer: action %0d char %0d eoi %0d last %0d",
                   m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
        mismatch_cnt++;
      end else begin
        d = screen_q.pop_front();
        if (m_tuser[1:0] !== d.act || m_tdata !== {1'b0, d.ch} ||
            m_tuser[2] !== d.eoi || m_tlast !== d.last) begin
          if (mismatch_cnt < 10)
            $display("mismatch: expected action %0d char %0d eoi %0d last %0d,",
                     d.act, d.ch, d.eoi, d.last,
                     " got action %0d char %0d eoi %0d last %0d",
                     m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("terminal_line_editor_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_lines();
    test_random();
    test_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && screen_q.size() == 0) begin
      $display("terminal_line_editor_tb: PASS");
    end else begin
      $display("terminal_line_editor_tb: FAIL");
    end
    $finish;
  end

endmodule
